FILE: design/pstall_pkg.sv
// Shared types, codes and constants of the playback stall predictor.
package pstall_pkg;

	// operation codes
	localparam logic [1:0] OP_PKT   = 2'd0;
	localparam logic [1:0] OP_RESET = 2'd1;
	localparam logic [1:0] OP_CLEAR = 2'd2;

	// configuration register indexes
	localparam int unsigned CFG_IDX_W  = 2;
	localparam int unsigned CFG_DATA_W = 20;
	localparam logic [CFG_IDX_W-1:0] CFG_EDGE_CACHE   = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_FRAME_FACTOR = 2'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_RATE_MODE    = 2'd2;
	localparam logic [7:0] FRAME_FACTOR_RST = 8'd20;

	localparam int unsigned CNT_W = 4;
	localparam logic [CNT_W-1:0] STALL_MAX = 4'd10;

	// divider: queued_frames * 1000 / frame_rate
	localparam int unsigned DIV_W     = 26;
	localparam int unsigned RATE_W    = 10;
	localparam int unsigned DIV_STEPS = DIV_W;
	localparam int unsigned DCNT_W    = $clog2(DIV_STEPS + 1);
	localparam logic [DIV_W-1:0] MS_PER_S = 26'd1000;

	localparam logic [19:0]        CACHE_MIN_MS  = 20'd5000;
	localparam logic signed [48:0] START_MS      = 49'sd2000;
	localparam logic signed [48:0] CHECK_GAP_MS  = 49'sd200;
	localparam logic signed [50:0] LAG_STEP_MS   = 51'sd100;
	localparam logic signed [49:0] CLIENT_LOW_MS = -50'sd800;
	localparam logic [DIV_W-1:0]   SERVER_LOW_MS = 26'd2000;
	localparam logic [31:0]        DROP_LONG_MS  = 32'd2000;

	typedef struct packed {
		logic [1:0]  operation;
		logic        media_kind;
		logic [47:0] now_ms;
		logic [31:0] send_timestamp;
		logic [9:0]  frame_rate;
		logic [15:0] queued_frames;
	} in_t;

	typedef struct packed {
		logic       stall_res;
		logic       need_drop;
		logic       no_drop_switch;
		logic [3:0] stall_count;
		logic       reset_needed;
		logic       dropped_long_enough;
	} out_t;

	// controller to datapath
	typedef struct packed {
		logic load;
		logic first;
		logic div_start;
		logic elap;
		logic lag;
		logic diff;
		logic check;
		logic out_load;
	} cmd_t;

	// datapath to controller
	typedef struct packed {
		logic is_pkt;
		logic div_done;
		logic out_free;
	} sts_t;

endpackage

FILE: design/pstall_div.sv
// Restoring divider, one quotient bit per cycle.
module pstall_div import pstall_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              start,
	input  logic [DIV_W-1:0]  dividend,
	input  logic [RATE_W-1:0] divisor,
	output logic              busy,
	output logic [DIV_W-1:0]  quotient
);

	logic [DIV_W-1:0]  quo_q;
	logic [RATE_W-1:0] rem_q;
	logic [RATE_W-1:0] dvs_q;
	logic [DCNT_W-1:0] cnt_q;
	logic              busy_q;
	logic [RATE_W:0]   trial;
	logic              ge;
	logic [RATE_W:0]   rem_n;

	assign trial = {rem_q, quo_q[DIV_W-1]};
	assign ge    = trial >= {1'b0, dvs_q};
	assign rem_n = ge ? (trial - {1'b0, dvs_q}) : trial;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			cnt_q  <= '0;
		end else if (start) begin
			busy_q <= 1'b1;
			cnt_q  <= DCNT_W'(DIV_STEPS);
		end else if (busy_q) begin
			cnt_q <= cnt_q - 1'b1;
			if (cnt_q == DCNT_W'(1))
				busy_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			quo_q <= dividend;
			rem_q <= '0;
			dvs_q <= divisor;
		end else if (busy_q) begin
			quo_q <= {quo_q[DIV_W-2:0], ge};
			rem_q <= rem_n[RATE_W-1:0];
		end
	end

	assign busy     = busy_q;
	assign quotient = quo_q;

endmodule

FILE: design/pstall_dp.sv
// Datapath: configuration, stream state, lag arithmetic, stall counter and result register.
module pstall_dp import pstall_pkg::*; (
	input  logic                  clk,
	input  logic                  arst_n,
	input  cmd_t                  cmd,
	output sts_t                  sts,
	input  in_t                   in_data,
	output out_t                  out_data,
	output logic                  out_valid,
	input  logic                  out_stall,
	input  logic                  cfg_valid,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data
);

	// configuration
	logic [19:0] edge_cache_q;
	logic [7:0]  frame_factor_q;
	logic        mode_q;

	// current transaction
	in_t  item_q;
	logic resetn_q;
	logic stall_q;

	// stream state
	logic [47:0]        connect_q;
	logic [31:0]        first_audio_q;
	logic [31:0]        first_video_q;
	logic signed [49:0] last_lag_q;
	logic [47:0]        check_time_q;
	logic [CNT_W-1:0]   stall_cnt_q;
	logic [31:0]        last_audio_q;
	logic [31:0]        drop_start_q;
	logic               drop_q;
	logic               switch_q;

	// staged arithmetic
	logic signed [48:0] elapsed_s1;
	logic signed [48:0] gap_s1;
	logic [31:0]        tsdiff_s1;
	logic signed [49:0] lag_s2;
	logic signed [50:0] d_s3;

	out_t out_q;
	logic out_valid_q;

	logic             div_busy;
	logic [DIV_W-1:0] quotient;
	logic [DIV_W-1:0] dividend;
	logic [DIV_W-1:0] buf_ms;
	logic [CNT_W-1:0] cnt_next;
	logic             stall_hit;
	logic             cache_ok;
	logic             video;

	assign video    = item_q.media_kind;
	assign dividend = {10'b0, item_q.queued_frames} * MS_PER_S;

	pstall_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (cmd.div_start),
		.dividend (dividend),
		.divisor  (item_q.frame_rate),
		.busy     (div_busy),
		.quotient (quotient)
	);

	assign buf_ms   = (item_q.frame_rate == '0) ? '0 : quotient;
	assign cache_ok = edge_cache_q >= CACHE_MIN_MS;

	always_comb begin
		cnt_next = stall_cnt_q;
		if (d_s3 > LAG_STEP_MS || d_s3 < -LAG_STEP_MS) begin
			if (d_s3 < 0 && stall_cnt_q < STALL_MAX)
				cnt_next = stall_cnt_q + 1'b1;
			if (d_s3 > 0 && stall_cnt_q != '0)
				cnt_next = stall_cnt_q - 1'b1;
		end
		if (lag_s2 >= CLIENT_LOW_MS)
			cnt_next = STALL_MAX;
		if (buf_ms < SERVER_LOW_MS)
			cnt_next = '0;
		stall_hit = (buf_ms >= {7'b0, edge_cache_q[19:1]})
			&& ({4'b0, cnt_next} >= frame_factor_q);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			edge_cache_q   <= '0;
			frame_factor_q <= FRAME_FACTOR_RST;
			mode_q         <= 1'b0;
		end else if (cfg_valid) begin
			unique case (cfg_index)
				CFG_EDGE_CACHE:   edge_cache_q   <= cfg_data;
				CFG_FRAME_FACTOR: frame_factor_q <= cfg_data[7:0];
				CFG_RATE_MODE:    mode_q         <= cfg_data[0];
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			connect_q     <= '0;
			first_audio_q <= '0;
			first_video_q <= '0;
			last_lag_q    <= '0;
			check_time_q  <= '0;
			stall_cnt_q   <= '0;
			last_audio_q  <= '0;
			drop_start_q  <= '0;
			drop_q        <= 1'b0;
			switch_q      <= 1'b0;
			stall_q       <= 1'b0;
		end else if (cmd.load) begin
			stall_q <= 1'b0;
		end else if (cmd.first) begin
			case (item_q.operation)
				OP_PKT: begin
					// latch the first timestamp of this kind, and the connect time if none is set yet
					if (video && first_video_q == '0) begin
						first_video_q <= item_q.send_timestamp;
						if (connect_q == '0)
							connect_q <= item_q.now_ms;
					end
					if (!video && first_audio_q == '0) begin
						first_audio_q <= item_q.send_timestamp;
						if (connect_q == '0)
							connect_q <= item_q.now_ms;
					end
				end
				OP_RESET: begin
					first_audio_q <= '0;
					first_video_q <= '0;
					connect_q     <= item_q.now_ms;
					drop_q        <= 1'b0;
				end
				OP_CLEAR: begin
					drop_q   <= 1'b0;
					switch_q <= 1'b0;
				end
				default: ;
			endcase
		end else if (cmd.check && cache_ok) begin
			if (elapsed_s1 <= START_MS) begin
				last_lag_q <= lag_s2;
			end else begin
				if (!video)
					last_audio_q <= item_q.send_timestamp;
				if (gap_s1 > CHECK_GAP_MS) begin
					stall_cnt_q  <= cnt_next;
					check_time_q <= item_q.now_ms;
					last_lag_q   <= lag_s2;
					if (stall_hit) begin
						if (mode_q) begin
							stall_q  <= !switch_q;
							switch_q <= 1'b1;
						end else begin
							stall_q      <= !drop_q;
							drop_start_q <= video ? last_audio_q : item_q.send_timestamp;
							drop_q       <= 1'b1;
						end
					end
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			item_q   <= in_data;
			// compare against the first timestamp before it is latched
			resetn_q <= (in_data.operation == OP_PKT) && (in_data.media_kind
				? (in_data.send_timestamp < first_video_q)
				: (in_data.send_timestamp < first_audio_q));
		end
		if (cmd.elap) begin
			elapsed_s1 <= $signed({1'b0, item_q.now_ms}) - $signed({1'b0, connect_q});
			gap_s1     <= $signed({1'b0, item_q.now_ms}) - $signed({1'b0, check_time_q});
			tsdiff_s1  <= item_q.send_timestamp - (video ? first_video_q : first_audio_q);
		end
		if (cmd.lag)
			lag_s2 <= $signed({elapsed_s1[48], elapsed_s1}) - $signed({18'b0, tsdiff_s1});
		if (cmd.diff)
			d_s3 <= $signed({last_lag_q[49], last_lag_q}) - $signed({lag_s2[49], lag_s2});
		if (cmd.out_load) begin
			out_q.stall_res           <= stall_q;
			out_q.need_drop           <= drop_q;
			out_q.no_drop_switch      <= switch_q;
			out_q.stall_count         <= stall_cnt_q;
			out_q.reset_needed        <= resetn_q;
			out_q.dropped_long_enough <= (item_q.send_timestamp - drop_start_q) > DROP_LONG_MS;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			out_valid_q <= 1'b0;
		else if (cmd.out_load)
			out_valid_q <= 1'b1;
		else if (!out_stall)
			out_valid_q <= 1'b0;
	end

	assign sts.is_pkt   = item_q.operation == OP_PKT;
	assign sts.div_done = !div_busy;
	assign sts.out_free = !out_valid_q || !out_stall;

	assign out_data  = out_q;
	assign out_valid = out_valid_q;

`ifndef SYNTHESIS
	a_cnt_range: assert property (@(posedge clk) disable iff (!arst_n)
		stall_cnt_q <= STALL_MAX)
		else $error("stall counter above its ceiling");

	a_stall_flag: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && out_q.stall_res |-> out_q.need_drop || out_q.no_drop_switch)
		else $error("stall result without a raised flag");
`endif

endmodule

FILE: design/pstall_ctrl.sv
// Controller: sequences one transaction through the datapath.
module pstall_ctrl import pstall_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  logic in_valid,
	output logic in_stall,
	input  sts_t sts,
	output cmd_t cmd
);

	localparam logic [2:0] S_IDLE  = 3'd0;
	localparam logic [2:0] S_FIRST = 3'd1;
	localparam logic [2:0] S_ELAP  = 3'd2;
	localparam logic [2:0] S_LAG   = 3'd3;
	localparam logic [2:0] S_DIFF  = 3'd4;
	localparam logic [2:0] S_WAIT  = 3'd5;
	localparam logic [2:0] S_CHECK = 3'd6;
	localparam logic [2:0] S_DONE  = 3'd7;

	logic [2:0] state_q;
	logic [2:0] state_n;

	always_comb begin
		cmd     = '0;
		state_n = state_q;
		unique case (state_q)
			S_IDLE: begin
				if (in_valid) begin
					cmd.load = 1'b1;
					state_n  = S_FIRST;
				end
			end
			S_FIRST: begin
				cmd.first     = 1'b1;
				cmd.div_start = sts.is_pkt;
				state_n       = sts.is_pkt ? S_ELAP : S_DONE;
			end
			S_ELAP: begin
				cmd.elap = 1'b1;
				state_n  = S_LAG;
			end
			S_LAG: begin
				cmd.lag = 1'b1;
				state_n = S_DIFF;
			end
			S_DIFF: begin
				cmd.diff = 1'b1;
				state_n  = S_WAIT;
			end
			S_WAIT: begin
				if (sts.div_done)
					state_n = S_CHECK;
			end
			S_CHECK: begin
				cmd.check = 1'b1;
				state_n   = S_DONE;
			end
			S_DONE: begin
				// hold until the result register can take the transaction
				if (sts.out_free) begin
					cmd.out_load = 1'b1;
					state_n      = S_IDLE;
				end
			end
			default: state_n = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			state_q <= S_IDLE;
		else
			state_q <= state_n;
	end

	assign in_stall = state_q != S_IDLE;

`ifndef SYNTHESIS
	a_check_after_div: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.check |-> sts.div_done && $past(cmd.diff, 2) == 1'b0)
		else $error("check issued while the divider runs");

	a_div_start_pkt: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.div_start |=> !sts.div_done)
		else $error("divider did not start");
`endif

endmodule

FILE: design/playback_stall_predictor.sv
// Top level of the playback stall predictor: controller plus datapath.
//
//  channel  signals                                  direction  payload
//  in       in_valid, in_stall, in_data               input      in_t
//  out      out_valid, out_stall, out_data            output     out_t
//  cfg      cfg_valid, cfg_ready, cfg_index, cfg_data input      register index and data
//
// A media packet's result waits on the 26-step restoring divider that forms the
// queued buffer in ms; the lag arithmetic runs alongside it. Reset and clear
// operations skip the divider and the lag arithmetic.
// One transaction is in work at a time; the result register lets the next
// transaction enter while a result waits on out_stall.
// arst_n clears the stream state and loads the register defaults.
module playback_stall_predictor import pstall_pkg::*; (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  in_valid,
	output logic                  in_stall,
	input  in_t                   in_data,
	output logic                  out_valid,
	input  logic                  out_stall,
	output out_t                  out_data,
	input  logic                  cfg_valid,
	output logic                  cfg_ready,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data
);

	cmd_t cmd;
	sts_t sts;

	assign cfg_ready = 1'b1;

	pstall_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_stall (in_stall),
		.sts      (sts),
		.cmd      (cmd)
	);

	pstall_dp u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (cmd),
		.sts       (sts),
		.in_data   (in_data),
		.out_data  (out_data),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.cfg_valid (cfg_valid),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

endmodule

FILE: tb/playback_stall_predictor_test.sv
// Self-checking testbench for the playback stall predictor: stalled handshakes, scoreboard.
`timescale 1ns / 100ps

module playback_stall_predictor_test;
	import pstall_pkg::*;

	localparam logic [1:0] OP_UNUSED   = 2'd3;
	localparam logic       KIND_AUDIO  = 1'b0;
	localparam logic       KIND_VIDEO  = 1'b1;
	localparam logic       MODE_DROP   = 1'b0;
	localparam logic       MODE_SWITCH = 1'b1;

	localparam longint MIN_CACHE  = 5000;
	localparam longint YOUNG_MS   = 2000;
	localparam longint GAP_MS     = 200;
	localparam longint LAG_MARGIN = 100;
	localparam longint LAG_FLOOR  = -800;
	localparam longint BUF_FLOOR  = 2000;
	localparam longint DROP_AGE   = 2000;

	localparam int HOLD_CYCLES   = 400;
	localparam int SETTLE_CYCLES = 40;
	localparam int CYCLE_LIMIT   = 400000;

	class stall_scoreboard;
		logic [19:0] cache_ms;
		logic [7:0]  frame_factor;
		logic        rate_mode;
		logic [47:0] connect_time;
		logic [31:0] first_audio;
		logic [31:0] first_video;
		longint      last_lag;
		logic [47:0] check_time;
		logic [3:0]  stall_cnt;
		logic [31:0] last_audio_ts;
		logic [31:0] drop_start;
		bit          drop_flag;
		bit          switch_flag;
		out_t        expected_q[$];
		int          errors;
		int          n_results;
		int          n_raised;
		int          n_ts_resets;
		int          n_long_drops;

		function new();
			cache_ms = '0;
			frame_factor = FRAME_FACTOR_RST;
			rate_mode = MODE_DROP;
			connect_time = '0;
			first_audio = '0;
			first_video = '0;
			last_lag = 0;
			check_time = '0;
			stall_cnt = '0;
			last_audio_ts = '0;
			drop_start = '0;
			drop_flag = 1'b0;
			switch_flag = 1'b0;
			errors = 0;
			n_results = 0;
			n_raised = 0;
			n_ts_resets = 0;
			n_long_drops = 0;
		endfunction

		task report(string msg);
			// keep the log short when the block is badly off
			if (errors < 100)
				$display("MISMATCH result %0d: %s", n_results, msg);
			errors++;
		endtask

		function void set_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
			case (idx)
				CFG_EDGE_CACHE:   cache_ms = data;
				CFG_FRAME_FACTOR: frame_factor = data[7:0];
				CFG_RATE_MODE:    rate_mode = data[0];
				default: ;
			endcase
		endfunction

		function int pending();
			return expected_q.size();
		endfunction

		// Media packet: latch first timestamps, then run the stall check.
		function bit run_packet(in_t it);
			bit          video;
			bit          raised;
			logic [31:0] first;
			logic [31:0] since;
			longint      now_l, conn_l, check_l, since_l, elapsed, lag, diff;
			longint      buffer_ms, queued_l, rate_l, half_l;
			video = (it.media_kind == KIND_VIDEO);
			raised = 1'b0;
			if (video) begin
				if (first_video == '0) begin
					first_video = it.send_timestamp;
					if (connect_time == '0) connect_time = it.now_ms;
				end
			end else begin
				if (first_audio == '0) begin
					first_audio = it.send_timestamp;
					if (connect_time == '0) connect_time = it.now_ms;
				end
			end
			if (cache_ms < MIN_CACHE) return 1'b0;

			first = video ? first_video : first_audio;
			now_l = longint'(it.now_ms);
			conn_l = longint'(connect_time);
			elapsed = now_l - conn_l;
			since = it.send_timestamp - first;
			since_l = longint'(since);
			lag = elapsed - since_l;
			if (elapsed <= YOUNG_MS) begin
				last_lag = lag;
				return 1'b0;
			end
			if (!video) last_audio_ts = it.send_timestamp;

			buffer_ms = 0;
			if (it.frame_rate != '0) begin
				queued_l = longint'(it.queued_frames);
				rate_l = longint'(it.frame_rate);
				buffer_ms = (queued_l * 1000) / rate_l;
			end
			check_l = longint'(check_time);
			if (now_l - check_l <= GAP_MS) return 1'b0;

			diff = last_lag - lag;
			if (diff > LAG_MARGIN || diff < -LAG_MARGIN) begin
				if (diff < 0 && stall_cnt < STALL_MAX) stall_cnt++;
				if (diff > 0 && stall_cnt > 0) stall_cnt--;
			end
			if (lag >= LAG_FLOOR) stall_cnt = STALL_MAX;
			if (buffer_ms < BUF_FLOOR) stall_cnt = '0;
			check_time = it.now_ms;
			last_lag = lag;

			half_l = longint'(cache_ms >> 1);
			if (buffer_ms >= half_l && stall_cnt >= frame_factor) begin
				if (rate_mode == MODE_SWITCH) begin
					raised = !switch_flag;
					switch_flag = 1'b1;
				end else begin
					raised = !drop_flag;
					drop_start = video ? last_audio_ts : it.send_timestamp;
					drop_flag = 1'b1;
				end
			end
			return raised;
		endfunction

		function void note_input(in_t it);
			out_t        want;
			logic [31:0] delta;
			want = '0;
			case (it.operation)
				OP_PKT: begin
					want.reset_needed = (it.media_kind == KIND_VIDEO) ?
						(it.send_timestamp < first_video) : (it.send_timestamp < first_audio);
					want.stall_res = run_packet(it);
				end
				OP_RESET: begin
					first_audio = '0;
					first_video = '0;
					connect_time = it.now_ms;
					drop_flag = 1'b0;
				end
				OP_CLEAR: begin
					drop_flag = 1'b0;
					switch_flag = 1'b0;
				end
				default: ;
			endcase
			want.need_drop = drop_flag;
			want.no_drop_switch = switch_flag;
			want.stall_count = stall_cnt;
			delta = it.send_timestamp - drop_start;
			want.dropped_long_enough = (delta > DROP_AGE);
			expected_q.insert(expected_q.size(), want);
		endfunction

		task cmp(string name, logic [3:0] got, logic [3:0] want);
			if (got !== want)
				report($sformatf("%s got %0d want %0d", name, got, want));
		endtask

		task check_result(out_t got);
			out_t want;
			if (expected_q.size() == 0) begin
				report("result arrived with nothing outstanding");
				return;
			end
			want = expected_q.pop_front();
			cmp("stall_res", 4'(got.stall_res), 4'(want.stall_res));
			cmp("need_drop", 4'(got.need_drop), 4'(want.need_drop));
			cmp("no_drop_switch", 4'(got.no_drop_switch), 4'(want.no_drop_switch));
			cmp("stall_count", got.stall_count, want.stall_count);
			cmp("reset_needed", 4'(got.reset_needed), 4'(want.reset_needed));
			cmp("dropped_long_enough", 4'(got.dropped_long_enough),
				4'(want.dropped_long_enough));
			n_results++;
			if (want.stall_res) n_raised++;
			if (want.reset_needed) n_ts_resets++;
			if (want.dropped_long_enough) n_long_drops++;
		endtask
	endclass

	logic                  clk = 1'b0;
	logic                  arst_n;
	logic                  in_valid;
	logic                  in_stall;
	in_t                   in_data;
	logic                  out_valid;
	logic                  out_stall;
	out_t                  out_data;
	logic                  cfg_valid;
	logic                  cfg_ready;
	logic [CFG_IDX_W-1:0]  cfg_index;
	logic [CFG_DATA_W-1:0] cfg_data;

	stall_scoreboard sb;
	bit              no_idle;
	bit              hold_off_req;
	int              n_holds;
	int              items_sent;
	int              in_stall_cycles;
	int              cycles;
	logic [47:0]     wall_ms;

	playback_stall_predictor dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.in_data   (in_data),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.out_data  (out_data),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > CYCLE_LIMIT) begin
			$display("timeout after %0d cycles, %0d results outstanding", cycles, sb.pending());
			$display("simulation failed");
			$finish;
		end
	end

	// sample both channels before this edge's updates land
	always @(posedge clk) begin
		if (arst_n) begin
			if (in_valid && !in_stall) sb.note_input(in_data);
			if (in_valid && in_stall) in_stall_cycles++;
			if (out_valid && !out_stall) sb.check_result(out_data);
		end
	end

	// result side: random stalls per transaction, one long hold-off on request
	initial begin : result_sink
		int hold;
		int k;
		out_stall <= 1'b0;
		forever begin
			if (hold_off_req) begin
				hold_off_req = 1'b0;
				out_stall <= 1'b1;
				k = 0;
				while (k < HOLD_CYCLES) begin
					@(posedge clk);
					k++;
				end
				n_holds++;
			end else begin
				hold = no_idle ? 0 : $urandom_range(0, 5);
				if (hold > 0) begin
					out_stall <= 1'b1;
					repeat (hold) @(posedge clk);
				end
			end
			out_stall <= 1'b0;
			do @(posedge clk); while (!out_valid);
		end
	end

	function automatic in_t mk_item(logic [1:0] op, logic kind, logic [47:0] now,
			logic [31:0] ts, logic [9:0] rate, logic [15:0] queued);
		in_t it;
		it.operation = op;
		it.media_kind = kind;
		it.now_ms = now;
		it.send_timestamp = ts;
		it.frame_rate = rate;
		it.queued_frames = queued;
		return it;
	endfunction

	// Random fields; while checks run, packets keep the stream clock so the
	// check window is not pushed out of reach.
	function automatic in_t noise_item(bit active);
		in_t         it;
		logic [63:0] raw;
		raw = {$urandom, $urandom};
		it = mk_item(2'($urandom_range(0, 3)), 1'($urandom_range(0, 1)), raw[47:0], $urandom,
			10'($urandom), 16'($urandom));
		if (active && it.operation == OP_PKT) it.now_ms = wall_ms;
		return it;
	endfunction

	task automatic send_item(input in_t item);
		int gap;
		gap = no_idle ? 0 : $urandom_range(0, 5);
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1'b1;
		in_data <= item;
		do @(posedge clk); while (in_stall);
		items_sent++;
	endtask

	task automatic wait_idle();
		in_valid <= 1'b0;
		@(posedge clk);
		while (sb.pending() != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= data;
		do @(posedge clk); while (!cfg_ready);
		sb.set_reg(idx, data);
	endtask

	task automatic configure(input logic [19:0] cache, input logic [7:0] ff, input logic mode);
		write_reg(CFG_EDGE_CACHE, cache);
		write_reg(CFG_FRAME_FACTOR, {12'd0, ff});
		write_reg(CFG_RATE_MODE, {19'd0, mode});
		cfg_valid <= 1'b0;
	endtask

	// Sessions: a reset, then packets whose send times follow the stream
	// clock with a drifting skew, mixed with clears, resets and noise.
	task automatic run_phase(input logic [19:0] cache, input logic [7:0] ff, input logic mode,
			input int quota, input bit long_hold);
		int          sent, n, i, pick, jitter, skew;
		bit          active;
		logic [47:0] start_ms, span;
		logic [31:0] base_ts, ts;
		logic [9:0]  rate;
		logic [15:0] queued;
		in_t         item;
		wait_idle();
		configure(cache, ff, mode);
		if (long_hold) hold_off_req = 1'b1;
		active = (cache >= MIN_CACHE);
		sent = 0;
		while (sent < quota) begin
			n = $urandom_range(15, 50);
			if (n > quota - sent) n = quota - sent;
			no_idle = ($urandom_range(0, 3) == 0);
			wall_ms = wall_ms + $urandom_range(1000, 1 << 20);
			start_ms = wall_ms;
			base_ts = ($urandom_range(0, 3) == 0) ? 32'hFFFF_FFFF - $urandom_range(0, 20000)
				: $urandom;
			skew = 0;
			send_item(mk_item(OP_RESET, 1'($urandom_range(0, 1)), wall_ms, $urandom,
				10'($urandom), 16'($urandom)));
			sent++;
			for (i = 1; i < n; i++) begin
				wall_ms = wall_ms + $urandom_range(0, 450);
				pick = $urandom_range(0, 99);
				if (pick < 3)
					item = mk_item(OP_CLEAR, 1'($urandom_range(0, 1)), wall_ms, $urandom,
						10'($urandom), 16'($urandom));
				else if (pick < 5)
					item = mk_item(OP_RESET, 1'($urandom_range(0, 1)), wall_ms, $urandom,
						10'($urandom), 16'($urandom));
				else if (pick < 12)
					item = noise_item(active);
				else begin
					if ($urandom_range(0, 7) == 0) begin
						jitter = $urandom_range(150, 1200);
						if ($urandom_range(0, 1)) jitter = -jitter;
					end else
						jitter = $urandom_range(0, 120) - 60;
					// keep the lag wandering on both sides of the client floor
					if (skew + jitter > 1500 || skew + jitter < -2500) jitter = -jitter;
					skew += jitter;
					span = wall_ms - start_ms;
					ts = base_ts + span[31:0] + skew;
					case ($urandom_range(0, 19)) inside
						0:       rate = '0;
						[1:3]:   rate = 10'($urandom_range(1, 1023));
						[4:5]:   rate = 10'd25;
						[6:8]:   rate = 10'd60;
						default: rate = 10'd30;
					endcase
					queued = ($urandom_range(0, 3) == 0) ? 16'($urandom_range(0, 200))
						: 16'($urandom_range(0, 65535));
					item = mk_item(OP_PKT, 1'($urandom_range(0, 1)), wall_ms, ts, rate, queued);
				end
				send_item(item);
				sent++;
			end
		end
		no_idle = 1'b0;
	endtask

	initial begin
		sb = new();
		no_idle = 1'b0;
		hold_off_req = 1'b0;
		n_holds = 0;
		items_sent = 0;
		in_stall_cycles = 0;
		cycles = 0;
		wall_ms = 48'd100000;
		arst_n <= 1'b0;
		in_valid <= 1'b0;
		in_data <= '0;
		cfg_valid <= 1'b0;
		cfg_index <= '0;
		cfg_data <= '0;
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// register defaults: first timestamps latch, no checks
		send_item(mk_item(OP_PKT, KIND_AUDIO, 48'd0, 32'd0, 10'd0, 16'd0));
		send_item(mk_item(OP_PKT, KIND_AUDIO, 48'd100, 32'd1000, 10'd30, 16'd300));
		send_item(mk_item(OP_PKT, KIND_AUDIO, 48'd150, 32'd999, 10'd30, 16'd300));
		send_item(mk_item(OP_PKT, KIND_VIDEO, 48'hFFFF_FFFF_FFFF, 32'hFFFF_FFFF, 10'h3FF,
			16'hFFFF));
		send_item(mk_item(OP_PKT, KIND_VIDEO, 48'd200, 32'd5, 10'd1, 16'd0));
		send_item(mk_item(OP_UNUSED, KIND_VIDEO, 48'hFFFF_FFFF_FFFF, 32'hFFFF_FFFF, 10'h3FF,
			16'hFFFF));
		send_item(mk_item(OP_CLEAR, KIND_AUDIO, 48'd300, 32'd2001, 10'd0, 16'd0));
		send_item(mk_item(OP_RESET, KIND_AUDIO, 48'd10000, 32'd2000, 10'd0, 16'd0));

		// smallest active cache, zero frame factor, drop mode
		wait_idle();
		configure(20'd5000, 8'd0, MODE_DROP);
		send_item(mk_item(OP_PKT, KIND_AUDIO, 48'd10100, 32'd100, 10'd30, 16'd900));
		send_item(mk_item(OP_PKT, KIND_AUDIO, 48'd12000, 32'd2000, 10'd30, 16'd900));
		send_item(mk_item(OP_PKT, KIND_AUDIO, 48'd12500, 32'd2400, 10'd0, 16'd900));
		send_item(mk_item(OP_PKT, KIND_AUDIO, 48'd12700, 32'd2600, 10'd30, 16'd90));
		send_item(mk_item(OP_PKT, KIND_AUDIO, 48'd12701, 32'd2601, 10'd30, 16'd90));
		send_item(mk_item(OP_PKT, KIND_VIDEO, 48'd13000, 32'd7000, 10'd1, 16'hFFFF));
		send_item(mk_item(OP_PKT, KIND_AUDIO, 48'd13300, 32'd6000, 10'd30, 16'd900));
		send_item(mk_item(OP_CLEAR, KIND_AUDIO, 48'd13400, 32'd1, 10'd0, 16'd0));
		send_item(mk_item(OP_PKT, KIND_AUDIO, 48'd13600, 32'd2600, 10'd30, 16'd900));

		// largest cache, frame factor beyond the counter's reach
		wait_idle();
		configure(20'hFFFFF, 8'hFF, MODE_SWITCH);
		send_item(mk_item(OP_PKT, KIND_VIDEO, 48'd14000, 32'd7500, 10'd60, 16'hFFFF));
		send_item(mk_item(OP_PKT, KIND_AUDIO, 48'd14300, 32'd4000, 10'd60, 16'hFFFF));

		// switch mode stall; a reset keeps the switch flag
		wait_idle();
		configure(20'd6000, 8'd10, MODE_SWITCH);
		send_item(mk_item(OP_PKT, KIND_AUDIO, 48'd14600, 32'd4300, 10'h3FF, 16'hFFFF));
		send_item(mk_item(OP_RESET, KIND_VIDEO, 48'd15000, 32'd0, 10'd0, 16'd0));
		send_item(mk_item(OP_CLEAR, KIND_VIDEO, 48'd15100, 32'd0, 10'd0, 16'd0));

		run_phase(20'd5000, 8'd10, MODE_DROP, 160, 1'b0);
		run_phase(20'hFFFFF, 8'd0, MODE_SWITCH, 160, 1'b0);
		run_phase(20'd4999, 8'd0, MODE_DROP, 160, 1'b0);
		run_phase(20'($urandom_range(5000, 30000)), 8'($urandom_range(1, 10)),
			1'($urandom_range(0, 1)), 160, 1'b1);
		run_phase(20'd0, 8'hFF, MODE_SWITCH, 160, 1'b0);
		run_phase(20'd5000, 8'd11, MODE_DROP, 160, 1'b0);
		run_phase(20'($urandom_range(5000, 30000)), 8'($urandom_range(0, 10)), MODE_SWITCH,
			160, 1'b0);
		run_phase(20'd5000, 8'd10, MODE_DROP, 160, 1'b0);

		wait_idle();
		$display("covered %0d transactions in, %0d results checked: %0d stalls raised,",
			items_sent, sb.n_results, sb.n_raised);
		$display("%0d timestamp resets, %0d long drops, %0d input stall cycles, %0d long holds",
			sb.n_ts_resets, sb.n_long_drops, in_stall_cycles, n_holds);
		if (sb.errors == 0)
			$display("simulation ok");
		else
			$display("simulation failed");
		$finish;
	end

endmodule

FILE: playback_stall_predictor.f
design/pstall_pkg.sv
design/pstall_div.sv
design/pstall_dp.sv
design/pstall_ctrl.sv
design/playback_stall_predictor.sv
tb/playback_stall_predictor_test.sv
